/* rtl/core/stq_pkg.sv */
// stq_pkg: shared constants and codes of the speaker toggle sample queue
// no dependencies; imported by stq_ring, stq_ctrl and the top level
`default_nettype none

package stq_pkg;

   // defaults for the top-level parameters
   localparam int unsigned QUEUE_DEPTH_DEFAULT       = 4096;
   localparam int unsigned CYCLES_PER_SAMPLE_DEFAULT = 23;

   localparam int unsigned SAMPLE_W = 8;
   localparam int unsigned COUNT_W  = 64;

   // request codes
   localparam logic REQ_TOGGLE = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   // register file
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_HIGH_LEVEL_ADDR = 3'h0;
   localparam logic [SAMPLE_W-1:0]   HIGH_LEVEL_RESET    = 8'd128;

endpackage

`default_nettype wire

/* rtl/core/stq_ring.sv */
// stq_ring: sample ring storage, one write port and one read port
// read data is registered; depends on stq_pkg
`default_nettype none

module stq_ring
   import stq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   localparam int unsigned AW = $clog2(QUEUE_DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire logic [SAMPLE_W-1:0] wr_data,
   input  wire logic                rd_en,
   input  wire logic [AW-1:0]       rd_addr,
   output logic      [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] mem [QUEUE_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/stq_ctrl.sv */
// stq_ctrl: request sequencer, head/tail pointers, level and fill engine
// drives the ring ports of stq_ring and holds the result register; depends on stq_pkg
`default_nettype none

module stq_ctrl
   import stq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH       = QUEUE_DEPTH_DEFAULT,
   parameter int unsigned CYCLES_PER_SAMPLE = CYCLES_PER_SAMPLE_DEFAULT,
   localparam int unsigned AW = $clog2(QUEUE_DEPTH)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [SAMPLE_W-1:0] high_level,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_type,
   input  wire logic [COUNT_W-1:0]  req_cycle_count,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [SAMPLE_W-1:0] rsp_sample,
   output logic                     rsp_queue_empty,
   output logic                     ring_we,
   output logic      [AW-1:0]       ring_waddr,
   output logic      [SAMPLE_W-1:0] ring_wdata,
   output logic                     ring_re,
   output logic      [AW-1:0]       ring_raddr,
   input  wire logic [SAMPLE_W-1:0] ring_rdata
);

   // elapsed counts up to the depth itself are kept
   localparam int unsigned EW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [AW-1:0] LAST_ADDR  = AW'(QUEUE_DEPTH - 1);
   localparam logic [EW-1:0] DEPTH_W    = EW'(QUEUE_DEPTH);
   localparam bit            CPS_FITS   = (CYCLES_PER_SAMPLE <= QUEUE_DEPTH);
   localparam logic [EW-1:0] CPS_W      = CPS_FITS ? EW'(CYCLES_PER_SAMPLE) : '0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FILL,
      ST_RESP
   } state_type;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  cc_ff, cc_in;
   logic [COUNT_W-1:0]  last_ff, last_in;
   logic [SAMPLE_W-1:0] level_ff, level_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [AW-1:0]       tail_ff, tail_in;
   logic [AW-1:0]       fill_addr_ff, fill_addr_in;
   logic [EW-1:0]       rem_ff, rem_in;
   logic                wrapped_ff, wrapped_in;
   logic                rd_empty_ff, rd_empty_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                rsp_empty_ff, rsp_empty_in;

   logic [COUNT_W-1:0]  base_cycle;
   logic [COUNT_W:0]    diff;
   logic                backwards;
   logic                big_gap;
   logic                fill_go;
   logic                rsp_load;
   logic                req_take;
   logic [SAMPLE_W-1:0] level_flip;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_take   = req_valid && req_ready;

   // a zero count means no toggle seen yet: elapsed becomes zero
   assign base_cycle = (last_ff == '0) ? cc_ff : last_ff;
   assign diff       = {1'b0, cc_ff} - {1'b0, base_cycle};
   assign backwards  = diff[COUNT_W];
   assign big_gap    = (|diff[COUNT_W-1:EW]) || (diff[EW-1:0] > DEPTH_W);

   assign fill_go    = CPS_FITS && (rem_ff >= CPS_W);
   assign level_flip = (level_ff == '0) ? high_level : '0;
   assign rsp_load   = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_ready);

   assign ring_we    = (state_ff == ST_FILL) && fill_go;
   assign ring_waddr = fill_addr_ff;
   assign ring_wdata = level_ff;
   assign ring_re    = req_take && (req_type == REQ_READ);
   assign ring_raddr = head_ff;

   always_comb begin
      state_in      = state_ff;
      cc_in         = cc_ff;
      last_in       = last_ff;
      level_in      = level_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      fill_addr_in  = fill_addr_ff;
      rem_in        = rem_ff;
      wrapped_in    = wrapped_ff;
      rd_empty_in   = rd_empty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_empty_in  = rsp_empty_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_type == REQ_READ) begin
                  rd_empty_in = (head_ff == tail_ff);
                  state_in    = ST_RESP;
               end else begin
                  cc_in    = req_cycle_count;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            last_in  = cc_ff;
            state_in = ST_IDLE;
            if (!backwards) begin
               if (big_gap) begin
                  head_in  = '0;
                  tail_in  = '0;
                  level_in = level_flip;
               end else begin
                  rem_in       = diff[EW-1:0];
                  fill_addr_in = tail_ff;
                  wrapped_in   = 1'b0;
                  state_in     = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            // one entry per cycle while a whole sample period remains
            if (fill_go) begin
               rem_in = rem_ff - CPS_W;
               if (fill_addr_ff == LAST_ADDR) begin
                  fill_addr_in = '0;
                  wrapped_in   = 1'b1;
               end else begin
                  fill_addr_in = fill_addr_ff + 1'b1;
               end
            end else begin
               tail_in = fill_addr_ff;
               // overrun across the end of the ring drops the queued samples
               if (wrapped_ff && (fill_addr_ff > head_ff)) begin
                  head_in = fill_addr_ff;
               end
               level_in = level_flip;
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_empty_in = rd_empty_ff;
               if (rd_empty_ff) begin
                  rsp_sample_in = level_ff;
               end else begin
                  rsp_sample_in = ring_rdata;
                  head_in       = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         level_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         level_ff     <= level_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cc_ff         <= cc_in;
      fill_addr_ff  <= fill_addr_in;
      rem_ff        <= rem_in;
      wrapped_ff    <= wrapped_in;
      rd_empty_ff   <= rd_empty_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_queue_empty = rsp_empty_ff;

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_ADDR)
      else $error("head pointer beyond ring");

   a_tail_range: assert property (@(posedge clock) disable iff (reset)
      tail_ff <= LAST_ADDR)
      else $error("tail pointer beyond ring");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && fill_go) |=> (rem_ff == $past(rem_ff) - CPS_W))
      else $error("fill remainder did not drop by one sample period");

   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rd_empty_ff) |=> (rsp_queue_empty && rsp_sample == $past(level_ff)))
      else $error("empty transaction did not return the current level");

endmodule

`default_nettype wire

/* rtl/core/speaker_toggle_sample_queue_core.sv */
// speaker_toggle_sample_queue_core: top level, register port and block wiring
// instantiates stq_ctrl and stq_ring; depends on stq_pkg
//
// Usage:
//   req channel (valid/ready): req_type selects a toggle at req_cycle_count or a
//   read of one sample. rsp channel (valid/ready) carries one transaction per read:
//   rsp_sample and rsp_queue_empty; toggles give no response.
//   A read passes through the response state: the ring's registered read is
//   issued when the read is accepted and its data is loaded into the response
//   register from that state, which waits while the register is still held. A
//   toggle passes through a check state and, unless it resyncs or clears, the
//   fill engine, which writes n = elapsed / CYCLES_PER_SAMPLE ring entries (at most
//   QUEUE_DEPTH / CYCLES_PER_SAMPLE), one per cycle, through the single write port.
//   req_ready is high only while the sequencer is idle; one at a time.
//   If the receiver stalls, the response waits in the output register and the
//   block still takes toggles; a following read waits until the register frees.
//   Reset (synchronous, active high) clears pointers, level, last count and the
//   response valid, and sets high_level to 128. There is no clearing pass: ring
//   entries hold no defined value until written.
//   csr high_level, byte address 0: users write it only while idle; not enforced.
`default_nettype none

module speaker_toggle_sample_queue_core
   import stq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH       = QUEUE_DEPTH_DEFAULT,
   parameter int unsigned CYCLES_PER_SAMPLE = CYCLES_PER_SAMPLE_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_type,
   input  wire logic [COUNT_W-1:0]    req_cycle_count,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic      [SAMPLE_W-1:0]   rsp_sample,
   output logic                       rsp_queue_empty,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int unsigned AW = $clog2(QUEUE_DEPTH);

   logic [SAMPLE_W-1:0] high_level_ff, high_level_in;
   logic                csr_write;

   logic                ring_we;
   logic [AW-1:0]       ring_waddr;
   logic [SAMPLE_W-1:0] ring_wdata;
   logic                ring_re;
   logic [AW-1:0]       ring_raddr;
   logic [SAMPLE_W-1:0] ring_rdata;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      high_level_in = high_level_ff;
      if (csr_write && (csr_paddr == CSR_HIGH_LEVEL_ADDR)) begin
         high_level_in = csr_pwdata[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_level_ff <= HIGH_LEVEL_RESET;
      end else begin
         high_level_ff <= high_level_in;
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_HIGH_LEVEL_ADDR: csr_prdata = {{(CSR_DATA_W-SAMPLE_W){1'b0}}, high_level_ff};
         default:             csr_prdata = '0;
      endcase
   end

   stq_ctrl #(
      .QUEUE_DEPTH       (QUEUE_DEPTH),
      .CYCLES_PER_SAMPLE (CYCLES_PER_SAMPLE)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .high_level      (high_level_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_cycle_count (req_cycle_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample      (rsp_sample),
      .rsp_queue_empty (rsp_queue_empty),
      .ring_we         (ring_we),
      .ring_waddr      (ring_waddr),
      .ring_wdata      (ring_wdata),
      .ring_re         (ring_re),
      .ring_raddr      (ring_raddr),
      .ring_rdata      (ring_rdata)
   );

   stq_ring #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_waddr),
      .wr_data (ring_wdata),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

endmodule

`default_nettype wire

/* tb/speaker_toggle_sample_queue_core_tb.sv */
// speaker_toggle_sample_queue_core_tb: self-checking bench for the toggle sample queue
// drives toggle/read transactions and the high_level register, predicts every read
// response in a local copy of the ring; depends on stq_pkg and the core RTL
`default_nettype none

module speaker_toggle_sample_queue_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import stq_pkg::*;

   localparam int unsigned DEPTH        = QUEUE_DEPTH_DEFAULT;
   localparam int unsigned CPS          = CYCLES_PER_SAMPLE_DEFAULT;
   localparam int unsigned DRAIN_CYCLES = DEPTH / CPS + 16;
   localparam int unsigned LONG_HOLD    = 600;
   localparam int unsigned QUIET_LIMIT  = 5000;
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_ITEMS  = 200;

   typedef struct {
      logic             kind;
      logic [COUNT_W-1:0] count;
   } speaker_req_type;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                empty;
   } sample_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = REQ_TOGGLE;
   logic [COUNT_W-1:0]    req_cycle_count = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0]   rsp_sample;
   logic                  rsp_queue_empty;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   speaker_toggle_sample_queue_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_cycle_count (req_cycle_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample      (rsp_sample),
      .rsp_queue_empty (rsp_queue_empty),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #6 clock = ~clock;

   speaker_req_type   pending_reqs[$];
   sample_result_type expected_samples[$];

   // predicted block state
   bit [SAMPLE_W-1:0] ring_image [DEPTH];
   int unsigned       rd_ptr = 0;
   int unsigned       wr_ptr = 0;
   bit [COUNT_W-1:0]  last_stamp = '0;
   bit [SAMPLE_W-1:0] wave_level = '0;
   bit [SAMPLE_W-1:0] high_level_cfg = HIGH_LEVEL_RESET;

   int          sample_mismatches = 0;
   int          csr_mismatches = 0;
   int unsigned snd_idle_pct = 0;
   int unsigned rcv_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   bit [COUNT_W-1:0] cpu_clock = 64'd20000;

   function automatic void flip_wave();
      wave_level = (wave_level == 0) ? high_level_cfg : '0;
   endfunction

   function automatic void predict_toggle(bit [COUNT_W-1:0] stamp);
      bit [COUNT_W-1:0] gap;
      int unsigned      fill;
      int unsigned      start;
      if (last_stamp == 0)
         last_stamp = stamp;
      // counter went backwards: resync only
      if (last_stamp > stamp) begin
         last_stamp = stamp;
         return;
      end
      gap = stamp - last_stamp;
      if (gap > DEPTH) begin
         rd_ptr = 0;
         wr_ptr = 0;
         last_stamp = stamp;
         flip_wave();
         return;
      end
      fill  = 32'(gap / CPS);
      start = wr_ptr % DEPTH;
      for (int unsigned i = 0; i < fill; i++)
         ring_image[(start + i) % DEPTH] = wave_level;
      wr_ptr = start + fill;
      // overrun only drags the head along when the tail wraps
      if (wr_ptr >= DEPTH) begin
         wr_ptr -= DEPTH;
         if (wr_ptr > rd_ptr)
            rd_ptr = wr_ptr;
      end
      last_stamp = stamp;
      flip_wave();
   endfunction

   function automatic void predict_read();
      sample_result_type res;
      if (rd_ptr == wr_ptr) begin
         res.sample = wave_level;
         res.empty  = 1'b1;
      end else begin
         res.sample = ring_image[rd_ptr % DEPTH];
         res.empty  = 1'b0;
         rd_ptr = (rd_ptr + 1) % DEPTH;
      end
      expected_samples.push_back(res);
   endfunction

   // request driver
   always @(posedge clock) begin
      bit fire;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            if (req_type == REQ_READ)
               predict_read();
            else
               predict_toggle(req_cycle_count);
            void'(pending_reqs.pop_front());
         end
         if (req_valid && !fire) begin
            // hold the transaction until accepted
         end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
            req_valid       <= 1'b1;
            req_type        <= pending_reqs[0].kind;
            req_cycle_count <= pending_reqs[0].count;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response ready, with an occasional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_ready    <= 1'b0;
         hold_left    <= LONG_HOLD;
         holds_served <= holds_served + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      sample_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t unexpected rsp transaction: expected none, actual sample %0d empty %0b",
                     $time, rsp_sample, rsp_queue_empty);
            sample_mismatches++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample !== want.sample) begin
               $display("%0t rsp_sample expected %0d actual %0d",
                        $time, want.sample, rsp_sample);
               sample_mismatches++;
            end
            if (rsp_queue_empty !== want.empty) begin
               $display("%0t rsp_queue_empty expected %0b actual %0b",
                        $time, want.empty, rsp_queue_empty);
               sample_mismatches++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
         $display("speaker_toggle_sample_queue_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_access(input bit write, input bit [CSR_DATA_W-1:0] wdata,
                             output bit [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_HIGH_LEVEL_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_high_level(input bit [SAMPLE_W-1:0] value);
      bit [CSR_DATA_W-1:0] rdata;
      csr_access(1'b1, CSR_DATA_W'(value), rdata);
      high_level_cfg = value;
      csr_access(1'b0, '0, rdata);
      if (rdata !== CSR_DATA_W'(value)) begin
         $display("%0t high_level readback expected %0d actual %0d", $time, value, rdata);
         csr_mismatches++;
      end
   endtask

   task automatic queue_req(input logic kind, input logic [COUNT_W-1:0] count);
      speaker_req_type item;
      item.kind  = kind;
      item.count = count;
      pending_reqs.push_back(item);
   endtask

   task automatic wait_until_drained();
      while (pending_reqs.size() != 0 || req_valid || expected_samples.size() != 0)
         @(posedge clock);
   endtask

   // mostly a steadily advancing cycle counter, with resyncs, clears and wild values
   task automatic queue_random_reqs(input int unsigned count, input int unsigned read_pct);
      int unsigned      pick;
      bit [COUNT_W-1:0] step;
      for (int unsigned k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < read_pct) begin
            queue_req(REQ_READ, {$urandom, $urandom});
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 24) begin
               cpu_clock += $urandom_range(0, 200);
            end else if (pick < 64) begin
               cpu_clock += $urandom_range(0, DEPTH);
            end else if (pick < 80) begin
               cpu_clock += $urandom_range(DEPTH - 100, DEPTH);
            end else if (pick < 86) begin
               cpu_clock += $urandom_range(DEPTH + 1, 100000);
            end else if (pick < 91) begin
               step = COUNT_W'($urandom_range(1, 5000));
               if (cpu_clock > step)
                  cpu_clock -= step;
            end else if (pick < 94) begin
               cpu_clock = '0;
            end else if (pick < 97) begin
               cpu_clock = {$urandom, $urandom};
            end else begin
               cpu_clock = {COUNT_W{1'b1}} - $urandom_range(0, 8000);
            end
            queue_req(REQ_TOGGLE, cpu_clock);
         end
      end
   endtask

   initial begin
      bit [SAMPLE_W-1:0] phase_level [PHASES];
      int unsigned       phase_reads [PHASES];
      phase_level = '{8'd0, 8'd128, 8'd1, 8'd127, 8'd0, 8'd64, 8'd128, 8'd0};
      phase_reads = '{50, 70, 40, 93, 60, 97, 55, 75};
      phase_level[4] = SAMPLE_W'($urandom_range(0, 128));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed part, high_level still at its reset value
      queue_req(REQ_READ, '0);
      queue_req(REQ_TOGGLE, 64'd0);
      queue_req(REQ_TOGGLE, 64'd1000);
      queue_req(REQ_TOGGLE, 64'd5096);
      queue_req(REQ_TOGGLE, 64'd5118);
      queue_req(REQ_TOGGLE, 64'd5187);
      queue_req(REQ_READ, '1);
      queue_req(REQ_READ, '0);
      queue_req(REQ_TOGGLE, 64'd500);
      queue_req(REQ_TOGGLE, 64'd4597);
      queue_req(REQ_READ, '0);
      queue_req(REQ_TOGGLE, 64'd4643);
      queue_req(REQ_TOGGLE, 64'd4689);
      repeat (5) queue_req(REQ_READ, '0);
      queue_req(REQ_TOGGLE, {COUNT_W{1'b1}});
      queue_req(REQ_TOGGLE, 64'h8000_0000_0000_0000);
      queue_req(REQ_TOGGLE, 64'h8000_0000_0000_1000);
      queue_req(REQ_READ, '0);
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      for (int unsigned p = 0; p < PHASES; p++) begin
         set_high_level(phase_level[p]);
         case (p % 4)
            0: begin
               snd_idle_pct  <= 0;
               rcv_stall_pct <= 0;
            end
            1: begin
               snd_idle_pct  <= 57;
               rcv_stall_pct <= 0;
            end
            2: begin
               snd_idle_pct  <= 0;
               rcv_stall_pct <= 57;
            end
            default: begin
               snd_idle_pct  <= 17;
               rcv_stall_pct <= 17;
            end
         endcase
         if (p == 0)
            hold_requests <= hold_requests + 1;
         if (p == 2) begin
            // sender stops mid-phase until every response is back
            queue_random_reqs(PHASE_ITEMS / 2, phase_reads[p]);
            wait_until_drained();
            queue_random_reqs(PHASE_ITEMS / 2, phase_reads[p]);
         end else begin
            queue_random_reqs(PHASE_ITEMS, phase_reads[p]);
         end
         wait_until_drained();
         repeat (DRAIN_CYCLES) @(posedge clock);
      end

      if (sample_mismatches == 0 && csr_mismatches == 0 && expected_samples.size() == 0)
         $display("speaker_toggle_sample_queue_core: match");
      else
         $display("speaker_toggle_sample_queue_core: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/stq_pkg.sv
rtl/core/stq_ring.sv
rtl/core/stq_ctrl.sv
rtl/core/speaker_toggle_sample_queue_core.sv
tb/speaker_toggle_sample_queue_core_tb.sv
